[src/mct_pkg.sv]
package mct_pkg;

    localparam int INDEX_W   = 5;
    localparam int MAX_RANK  = 32;
    localparam int SCAN_W    = $clog2(MAX_RANK + 1);
    localparam int LEN_W     = $clog2(MAX_RANK + 1);
    localparam int SIZE_BINS = 17;
    localparam int BIN_W     = $clog2(SIZE_BINS);
    localparam int HIST_W    = 5;
    localparam int HIST_MAX  = 31;
    localparam int MAX_OUT   = 16;
    localparam int COUNT_W   = $clog2(MAX_OUT + 1);
    localparam int SIZE_W    = 5;
    localparam int DEG_W     = 2;

    typedef logic [INDEX_W-1:0] idx_t;
    typedef logic [DEG_W-1:0]   deg_t;

    localparam deg_t DEG_NONE = 2'd0;
    localparam deg_t DEG_ONE  = 2'd1;
    localparam deg_t DEG_TWO  = 2'd2;
    localparam deg_t DEG_MANY = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] loop_size;
        logic              result_last;
        logic              error;
    } result_t;

endpackage

[src/mct_ram.sv]
module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/mct_out_stage.sv]
module mct_out_stage
    import mct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  result_t           res,
    output logic              slot_free,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [SIZE_W-1:0] loop_size,
    output logic              result_last,
    output logic              error
);

    logic    valid_reg;
    result_t res_reg;

    // a held result leaves on the same edge a new one arrives
    assign slot_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = valid_reg;
    assign loop_size   = res_reg.loop_size;
    assign result_last = res_reg.result_last;
    assign error       = res_reg.error;

endmodule

[src/matching_cycle_type_core.sv]
// channel | handshake            | fields
// --------+----------------------+----------------------------------
// input   | in_valid / in_ready  | index_a, index_b, input_last
// output  | out_valid / out_ready| loop_size, result_last, error
//
// a pair: accept, then attach each end; a valid end with under two
// neighbours gets a neighbour-store write. last pair: degree sweep, then a
// scan that walks each cycle found, emission per bin and result, a clear.
// in_ready drops while a pair is attached and, on the last, until the set is
// done; a waiting result sits in an output register and stalls only emission.
// reset clears degrees, marks and histogram; the neighbour stores need none.
module matching_cycle_type_core
    import mct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [INDEX_W-1:0] index_a,
    input  logic [INDEX_W-1:0] index_b,
    input  logic              input_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SIZE_W-1:0] loop_size,
    output logic              result_last,
    output logic              error
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ATT_A,
        ST_ATT_B,
        ST_CHECK,
        ST_SCAN,
        ST_WALK_RD,
        ST_WALK_WT,
        ST_EMIT,
        ST_ERR,
        ST_CLEAR
    } state_t;

    state_t                   state_reg, state_next;
    idx_t                     a_reg, a_next;
    idx_t                     b_reg, b_next;
    logic                     last_reg, last_next;
    logic                     pair_bad_reg, pair_bad_next;
    logic                     bad_reg, bad_next;
    logic [SCAN_W-1:0]        scan_reg, scan_next;
    idx_t                     cur_reg, cur_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [COUNT_W-1:0]       total_reg, total_next;
    logic [COUNT_W-1:0]       sent_reg, sent_next;
    logic [BIN_W-1:0]         bin_reg, bin_next;
    logic [HIST_W-1:0]        cnt_reg, cnt_next;
    deg_t                     deg_reg [MAX_RANK];
    deg_t                     deg_next [MAX_RANK];
    logic [MAX_RANK-1:0]      vis_reg, vis_next;
    logic [HIST_W-1:0]        hist_reg [SIZE_BINS];
    logic [HIST_W-1:0]        hist_next [SIZE_BINS];

    logic                     we_one, we_two;
    idx_t                     waddr, wdata;
    idx_t                     n1, n2;
    logic                     load;
    result_t                  res;
    logic                     slot_free;

    idx_t                     scan_idx;
    idx_t                     att_v;
    logic [LEN_W-1:0]         half_w;
    logic [BIN_W-1:0]         half_bin;
    logic [BIN_W-1:0]         hist_addr;
    logic [HIST_W-1:0]        hist_rd;
    logic                     n1_ok, n2_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign scan_idx = scan_reg[INDEX_W-1:0];
    assign att_v    = (state_reg == ST_ATT_A) ? a_reg : b_reg;

    // neighbour stores: at most one write per pair end, one read per walk step
    assign waddr  = att_v;
    assign wdata  = (state_reg == ST_ATT_A) ? b_reg : a_reg;
    assign we_one = ((state_reg == ST_ATT_A) || (state_reg == ST_ATT_B)) && !pair_bad_reg
                    && (deg_reg[att_v] == DEG_NONE);
    assign we_two = ((state_reg == ST_ATT_A) || (state_reg == ST_ATT_B)) && !pair_bad_reg
                    && (deg_reg[att_v] == DEG_ONE);

    mct_ram #(.WIDTH(INDEX_W), .DEPTH(MAX_RANK)) u_ram_one (
        .clk   (clk),
        .we    (we_one),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cur_reg),
        .rdata (n1)
    );

    mct_ram #(.WIDTH(INDEX_W), .DEPTH(MAX_RANK)) u_ram_two (
        .clk   (clk),
        .we    (we_two),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cur_reg),
        .rdata (n2)
    );

    mct_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .res         (res),
        .slot_free   (slot_free),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .loop_size   (loop_size),
        .result_last (result_last),
        .error       (error)
    );

    // half the walk length, capped at the top bin
    assign half_w   = len_reg >> 1;
    assign half_bin = (half_w >= LEN_W'(SIZE_BINS - 1)) ? BIN_W'(SIZE_BINS - 1)
                                                       : half_w[BIN_W-1:0];
    assign hist_addr = (state_reg == ST_EMIT) ? bin_reg : half_bin;
    assign hist_rd   = hist_reg[hist_addr];

    assign n1_ok = ({1'b0, n1} < (INDEX_W+1)'(MAX_RANK)) && !vis_reg[n1];
    assign n2_ok = ({1'b0, n2} < (INDEX_W+1)'(MAX_RANK)) && !vis_reg[n2];

    always_comb
    begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        last_next     = last_reg;
        pair_bad_next = pair_bad_reg;
        bad_next      = bad_reg;
        scan_next     = scan_reg;
        cur_next      = cur_reg;
        len_next      = len_reg;
        total_next    = total_reg;
        sent_next     = sent_reg;
        bin_next      = bin_reg;
        cnt_next      = cnt_reg;
        deg_next      = deg_reg;
        vis_next      = vis_reg;
        hist_next     = hist_reg;
        load          = 1'b0;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_next        = index_a;
                    b_next        = index_b;
                    last_next     = input_last;
                    pair_bad_next = ({1'b0, index_a} >= (INDEX_W+1)'(MAX_RANK))
                                    || ({1'b0, index_b} >= (INDEX_W+1)'(MAX_RANK))
                                    || (index_a == index_b);
                    state_next    = ST_ATT_A;
                end
            end
            ST_ATT_A:
            begin
                if (pair_bad_reg)
                begin
                    bad_next = 1'b1;
                end
                else if (deg_reg[a_reg] != DEG_MANY)
                begin
                    deg_next[a_reg] = deg_reg[a_reg] + DEG_ONE;
                end
                state_next = ST_ATT_B;
            end
            ST_ATT_B:
            begin
                if (!pair_bad_reg && (deg_reg[b_reg] != DEG_MANY))
                begin
                    deg_next[b_reg] = deg_reg[b_reg] + DEG_ONE;
                end
                scan_next  = '0;
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (scan_reg == SCAN_W'(MAX_RANK))
                begin
                    scan_next  = '0;
                    total_next = '0;
                    state_next = bad_reg ? ST_ERR : ST_SCAN;
                end
                else
                begin
                    if ((deg_reg[scan_idx] == DEG_ONE) || (deg_reg[scan_idx] == DEG_MANY))
                    begin
                        bad_next = 1'b1;
                    end
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == SCAN_W'(MAX_RANK))
                begin
                    bin_next   = '0;
                    cnt_next   = '0;
                    sent_next  = '0;
                    state_next = (total_reg == '0) ? ST_ERR : ST_EMIT;
                end
                else if ((deg_reg[scan_idx] == DEG_TWO) && !vis_reg[scan_idx])
                begin
                    cur_next   = scan_idx;
                    len_next   = '0;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            ST_WALK_RD:
            begin
                vis_next[cur_reg] = 1'b1;
                len_next          = len_reg + LEN_W'(1);
                state_next        = ST_WALK_WT;
            end
            ST_WALK_WT:
            begin
                priority if (n1_ok)
                begin
                    cur_next   = n1;
                    state_next = ST_WALK_RD;
                end
                else if (n2_ok)
                begin
                    cur_next   = n2;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    if (hist_rd != HIST_W'(HIST_MAX))
                    begin
                        hist_next[half_bin] = hist_rd + HIST_W'(1);
                    end
                    if (total_reg != COUNT_W'(MAX_OUT))
                    begin
                        total_next = total_reg + COUNT_W'(1);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT:
            begin
                if (hist_rd == cnt_reg)
                begin
                    // bin exhausted, move on
                    if (bin_reg == BIN_W'(SIZE_BINS - 1))
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        bin_next = bin_reg + BIN_W'(1);
                        cnt_next = '0;
                    end
                end
                else if (slot_free)
                begin
                    load            = 1'b1;
                    res.loop_size   = SIZE_W'(bin_reg);
                    res.result_last = (sent_reg + COUNT_W'(1)) == total_reg;
                    res.error       = 1'b0;
                    cnt_next        = cnt_reg + HIST_W'(1);
                    sent_next       = sent_reg + COUNT_W'(1);
                    if ((sent_reg + COUNT_W'(1)) == total_reg)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    load            = 1'b1;
                    res.loop_size   = '0;
                    res.result_last = 1'b1;
                    res.error       = 1'b1;
                    state_next      = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                bad_next   = 1'b0;
                total_next = '0;
                vis_next   = '0;
                for (int i = 0; i < MAX_RANK; i++)
                begin
                    deg_next[i] = DEG_NONE;
                end
                for (int j = 0; j < SIZE_BINS; j++)
                begin
                    hist_next[j] = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bad_reg   <= 1'b0;
            total_reg <= '0;
            vis_reg   <= '0;
            for (int i = 0; i < MAX_RANK; i++)
            begin
                deg_reg[i] <= DEG_NONE;
            end
            for (int j = 0; j < SIZE_BINS; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            total_reg <= total_next;
            vis_reg   <= vis_next;
            deg_reg   <= deg_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_reg     <= last_next;
        pair_bad_reg <= pair_bad_next;
        scan_reg     <= scan_next;
        cur_reg      <= cur_next;
        len_reg      <= len_next;
        sent_reg     <= sent_next;
        bin_reg      <= bin_next;
        cnt_reg      <= cnt_next;
    end

endmodule
